FILE: rtl/hosts_line_tokenizer_core_defines.svh
// ----------------------------------------------------------------------------
// Hosts line tokenizer: assertion macros
// Concurrent checks on clk, disabled while rst_n is low; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef HOSTS_LINE_TOKENIZER_CORE_DEFINES_SVH
`define HOSTS_LINE_TOKENIZER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// property that must hold at every edge out of reset
`define HLT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("hosts line tokenizer: check failed");
// condition that must hold in the cycle after a trigger
`define HLT_ASSERT_NEXT(lbl, trig, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("hosts line tokenizer: sequence check failed");
`else
`define HLT_ASSERT(lbl, prop)
`define HLT_ASSERT_NEXT(lbl, trig, cons)
`endif

`endif

FILE: rtl/hlt_pkg.sv
// ----------------------------------------------------------------------------
// Hosts line tokenizer package
// Shared types, codes, character classes and recognizer step functions.
// ----------------------------------------------------------------------------
package hlt_pkg;

    localparam int POS_BITS_DEF = 20;
    localparam int TOK_POS_W    = 20;
    localparam int QUEUE_DEPTH  = 4;

    // token kinds
    localparam logic [2:0] K_NEWLINE = 3'd0;
    localparam logic [2:0] K_BLANKS  = 3'd1;
    localparam logic [2:0] K_COMMENT = 3'd2;
    localparam logic [2:0] K_IPV4    = 3'd3;
    localparam logic [2:0] K_IPV6    = 3'd4;
    localparam logic [2:0] K_HOST    = 3'd5;
    localparam logic [2:0] K_ERROR   = 3'd6;

    // characters
    localparam logic [15:0] CH_HT    = 16'h0009;
    localparam logic [15:0] CH_LF    = 16'h000A;
    localparam logic [15:0] CH_CR    = 16'h000D;
    localparam logic [15:0] CH_SP    = 16'h0020;
    localparam logic [15:0] CH_HASH  = 16'h0023;
    localparam logic [15:0] CH_DASH  = 16'h002D;
    localparam logic [15:0] CH_DOT   = 16'h002E;
    localparam logic [15:0] CH_COLON = 16'h003A;

    // IPv4 phases
    localparam logic [1:0] P_RUN  = 2'd0;
    localparam logic [1:0] P_ACC  = 2'd1;
    localparam logic [1:0] P_FAIL = 2'd2;

    // IPv6 phases
    localparam logic [2:0] V6_START = 3'd0;
    localparam logic [2:0] V6_C1    = 3'd1;
    localparam logic [2:0] V6_DC    = 3'd2;
    localparam logic [2:0] V6_SC    = 3'd3;
    localparam logic [2:0] V6_GS    = 3'd4;
    localparam logic [2:0] V6_GROUP = 3'd5;
    localparam logic [2:0] V6_ACC   = 3'd6;
    localparam logic [2:0] V6_FAIL  = 3'd7;

    // host name phases
    localparam logic [2:0] N_START = 3'd0;
    localparam logic [2:0] N_BODY  = 3'd1;
    localparam logic [2:0] N_SEP   = 3'd2;
    localparam logic [2:0] N_ACC   = 3'd3;
    localparam logic [2:0] N_FAIL  = 3'd4;

    typedef struct packed {
        logic [1:0] phase;
        logic [1:0] groups;
        logic [1:0] digits;
        logic [7:0] value;
    } v4_t;

    typedef struct packed {
        logic [2:0] phase;
        logic       dbl;
        logic [3:0] groups;
        logic [2:0] digits;
    } v6_t;

    typedef struct packed {
        logic [2:0]           kind;
        logic [TOK_POS_W-1:0] start_pos;
        logic [TOK_POS_W-1:0] end_pos;
        logic                 run_last;
        logic                 file_done;
    } tok_t;

    // up to two tokens from one character, slot 1 only with slot 0
    typedef struct packed {
        logic push;
        logic v0;
        logic v1;
        tok_t t0;
        tok_t t1;
    } slots_t;

    function automatic logic is_digit(input logic [15:0] c);
        return c inside {[16'h0030:16'h0039]};
    endfunction

    function automatic logic is_alpha(input logic [15:0] c);
        return c inside {[16'h0041:16'h005A], [16'h0061:16'h007A]};
    endfunction

    function automatic logic is_alnum(input logic [15:0] c);
        return is_digit(c) || is_alpha(c);
    endfunction

    function automatic logic is_hex(input logic [15:0] c);
        return is_digit(c) || (c inside {[16'h0041:16'h0046], [16'h0061:16'h0066]});
    endfunction

    function automatic logic is_blank(input logic [15:0] c);
        return (c == CH_SP) || (c == CH_HT);
    endfunction

    function automatic logic is_eol(input logic [15:0] c);
        return (c == CH_CR) || (c == CH_LF);
    endfunction

    // eof stands for the end-of-file pseudo character
    function automatic logic is_delim(input logic [15:0] c, input logic eof);
        return eof || is_blank(c) || is_eol(c) || (c == CH_HASH);
    endfunction

    function automatic v4_t v4_feed(input v4_t t, input logic [15:0] c, input logic eof);
        v4_t         r;
        logic [11:0] nv;
        r  = t;
        nv = 12'(t.value) * 12'd10 + 12'(c[3:0]);
        if (t.phase == P_RUN) begin
            if (is_delim(c, eof)) begin
                r.phase = (t.groups == 2'd3 && t.digits != 2'd0) ? P_ACC : P_FAIL;
            end else if (is_digit(c)) begin
                if (t.digits == 2'd3 || nv > 12'd255) begin
                    r.phase = P_FAIL;
                end else begin
                    r.value  = nv[7:0];
                    r.digits = t.digits + 2'd1;
                end
            end else if (c == CH_DOT) begin
                if (t.digits == 2'd0 || t.groups == 2'd3) begin
                    r.phase = P_FAIL;
                end else begin
                    r.groups = t.groups + 2'd1;
                    r.digits = 2'd0;
                    r.value  = 8'd0;
                end
            end else begin
                r.phase = P_FAIL;
            end
        end
        return r;
    endfunction

    function automatic v6_t v6_feed(input v6_t t, input logic [15:0] c, input logic eof);
        v6_t  r;
        logic hx;
        logic cl;
        logic dl;
        r  = t;
        hx = !eof && is_hex(c);
        cl = !eof && (c == CH_COLON);
        dl = is_delim(c, eof);
        case (t.phase)
            V6_START, V6_SC:
            begin
                if (cl) begin
                    r.phase = (t.phase == V6_START) ? V6_C1 : V6_DC;
                end else if (hx) begin
                    r.phase  = V6_GROUP;
                    r.digits = 3'd1;
                end else begin
                    r.phase = V6_FAIL;
                end
            end
            V6_C1:
            begin
                r.phase = cl ? V6_DC : V6_FAIL;
            end
            V6_DC:
            begin
                if (dl) begin
                    r.phase = V6_ACC;
                end else begin
                    r.dbl = 1'b1;
                    if (hx) begin
                        r.phase  = V6_GROUP;
                        r.digits = 3'd1;
                    end else begin
                        r.phase = V6_FAIL;
                    end
                end
            end
            V6_GS:
            begin
                if (hx) begin
                    r.phase  = V6_GROUP;
                    r.digits = 3'd1;
                end else begin
                    r.phase = V6_FAIL;
                end
            end
            V6_GROUP:
            begin
                if (hx && t.digits < 3'd4) begin
                    r.digits = t.digits + 3'd1;
                end else begin
                    if (t.groups < 4'd8) begin
                        r.groups = t.groups + 4'd1;
                    end
                    r.digits = 3'd0;
                    if (!t.dbl) begin
                        if (r.groups == 4'd8) begin
                            r.phase = dl ? V6_ACC : V6_FAIL;
                        end else begin
                            r.phase = cl ? V6_SC : V6_FAIL;
                        end
                    end else if (r.groups == 4'd7) begin
                        r.phase = dl ? V6_ACC : V6_FAIL;
                    end else if (cl) begin
                        r.phase = V6_GS;
                    end else begin
                        r.phase = dl ? V6_ACC : V6_FAIL;
                    end
                end
            end
            default:
            begin
                r = t;
            end
        endcase
        return r;
    endfunction

    function automatic logic [2:0] name_feed(input logic [2:0] n, input logic [15:0] c,
                                             input logic eof);
        logic [2:0] r;
        r = n;
        case (n)
            N_START:
            begin
                r = (!eof && is_alpha(c)) ? N_BODY : N_FAIL;
            end
            N_BODY:
            begin
                if (is_delim(c, eof)) begin
                    r = N_ACC;
                end else if (is_alnum(c)) begin
                    r = N_BODY;
                end else if (c == CH_DASH || c == CH_DOT) begin
                    r = N_SEP;
                end else begin
                    r = N_FAIL;
                end
            end
            N_SEP:
            begin
                r = (!eof && is_alnum(c)) ? N_BODY : N_FAIL;
            end
            default:
            begin
                r = n;
            end
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/hlt_char_if.sv
// ----------------------------------------------------------------------------
// Character channel
// One file character per transaction, with end-of-file mark.
// ----------------------------------------------------------------------------
interface hlt_char_if;
    logic        valid;
    logic        ready;
    logic [15:0] character;
    logic        final_char;

    modport source (output valid, character, final_char, input ready);
    modport sink   (input valid, character, final_char, output ready);
endinterface

FILE: rtl/hlt_tok_if.sv
// ----------------------------------------------------------------------------
// Token channel
// One closed token per transaction: kind, span and end marks.
// ----------------------------------------------------------------------------
interface hlt_tok_if;
    logic        valid;
    logic        ready;
    logic [2:0]  token_kind;
    logic [19:0] token_start;
    logic [19:0] token_end;
    logic        run_last;
    logic        file_done;

    modport source (output valid, token_kind, token_start, token_end, run_last, file_done,
                    input ready);
    modport sink   (input valid, token_kind, token_start, token_end, run_last, file_done,
                    output ready);
endinterface

FILE: rtl/hosts_line_tokenizer_core.sv
// Path: a token closed by a character goes through the queue write, then the output
//   register onto the token channel; it waits longer if other tokens are ahead of it.
// Throughput: one character per cycle; a character may close two tokens while the token
//   channel drains one per cycle, so input stalls once more than two tokens wait.
// Reset (rst_n low, asynchronous): position 0, lexer between tokens, queue empty.
// ----------------------------------------------------------------------------
// Hosts line tokenizer top level
// Streams hosts-file characters in, emits newline, blank, comment, address,
// host name and error tokens with their spans.
// ----------------------------------------------------------------------------
`include "hosts_line_tokenizer_core_defines.svh"

module hosts_line_tokenizer_core #(
    parameter int POS_BITS = hlt_pkg::POS_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    hlt_char_if.sink  chars,
    hlt_tok_if.source tokens
);
    import hlt_pkg::*;

    slots_t slots;     // tokens closed by the current character
    logic   space;     // queue can take two more tokens
    logic   not_empty;
    tok_t   head;
    logic   pop;

    // front: lexer state, recognizers, token closing
    hlt_front #(
        .POS_BITS (POS_BITS)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (chars),
        .space (space),
        .slots (slots)
    );

    // decoupling queue between lexer and output
    hlt_tok_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .slots     (slots),
        .space     (space),
        .not_empty (not_empty),
        .head      (head),
        .pop       (pop)
    );

    // back: output register on the token channel
    hlt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (not_empty),
        .head      (head),
        .pop       (pop),
        .tokens    (tokens)
    );

    // the last token of a file is always the last of its character
    `HLT_ASSERT(a_done_is_last, tokens.valid && tokens.file_done |-> tokens.run_last)
    // two tokens from one character leave the queue occupied
    `HLT_ASSERT_NEXT(a_two_slots, slots.push && slots.v1, !space || not_empty)
    // a newline is never empty unless the position has saturated
    `HLT_ASSERT(a_span_order, tokens.valid && tokens.token_kind == K_NEWLINE |->
        tokens.token_end != tokens.token_start ||
        tokens.token_end == TOK_POS_W'({POS_BITS{1'b1}}))

endmodule

FILE: rtl/hlt_front.sv
// ----------------------------------------------------------------------------
// Hosts line tokenizer front end
// Classifies each character, steps the recognizers, closes tokens.
// ----------------------------------------------------------------------------
module hlt_front #(
    parameter int POS_BITS = hlt_pkg::POS_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    hlt_char_if.sink        chars,
    input  logic            space,
    output hlt_pkg::slots_t slots
);
    import hlt_pkg::*;

    localparam logic [2:0] M_IDLE    = 3'd0;
    localparam logic [2:0] M_CR      = 3'd1;
    localparam logic [2:0] M_BLANKS  = 3'd2;
    localparam logic [2:0] M_COMMENT = 3'd3;
    localparam logic [2:0] M_ADDR    = 3'd4;
    localparam logic [2:0] M_NAME    = 3'd5;
    localparam logic [2:0] M_ERROR   = 3'd6;

    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [POS_BITS-1:0] tb_reg, tb_next;
    logic [2:0]          mode_reg, mode_next;
    logic                at_reg, at_next;
    v4_t                 v4_reg, v4_next;
    v6_t                 v6_reg, v6_next;
    logic [2:0]          name_reg, name_next;
    slots_t              sl;
    logic                accept;

    function automatic slots_t push(input slots_t s, input logic [2:0] k,
                                    input logic [POS_BITS-1:0] a,
                                    input logic [POS_BITS-1:0] b);
        slots_t r;
        tok_t   t;
        r           = s;
        t.kind      = k;
        t.start_pos = TOK_POS_W'(a);
        t.end_pos   = TOK_POS_W'(b);
        t.run_last  = 1'b0;
        t.file_done = 1'b0;
        if (!s.v0) begin
            r.v0 = 1'b1;
            r.t0 = t;
        end else if (!s.v1) begin
            r.v1 = 1'b1;
            r.t1 = t;
        end
        return r;
    endfunction

    assign chars.ready = space;
    assign accept      = chars.valid && space;

    always_comb
    begin
        logic [15:0]         c;
        logic [POS_BITS-1:0] p;
        logic [POS_BITS-1:0] pi;
        logic                fin;
        logic                do_begin;
        v4_t                 f4;
        v6_t                 f6;
        logic [2:0]          fn;
        c         = chars.character;
        fin       = chars.final_char;
        p         = pos_reg;
        pi        = (pos_reg == {POS_BITS{1'b1}}) ? pos_reg : pos_reg + 1'b1;
        pos_next  = pi;
        tb_next   = tb_reg;
        mode_next = mode_reg;
        at_next   = at_reg;
        v4_next   = v4_reg;
        v6_next   = v6_reg;
        name_next = name_reg;
        do_begin  = 1'b0;
        sl        = '0;
        f4        = '0;
        f6        = '0;
        fn        = N_START;

        case (mode_reg)
            M_CR:
            begin
                at_next = 1'b0;
                if (c == CH_LF) begin
                    sl        = push(sl, K_NEWLINE, tb_reg, pi);
                    mode_next = M_IDLE;
                end else begin
                    sl       = push(sl, K_NEWLINE, tb_reg, p);
                    do_begin = 1'b1;
                end
            end
            M_BLANKS:
            begin
                if (!is_blank(c)) begin
                    sl       = push(sl, K_BLANKS, tb_reg, p);
                    do_begin = 1'b1;
                end
            end
            M_COMMENT:
            begin
                if (is_eol(c)) begin
                    sl       = push(sl, K_COMMENT, tb_reg, p);
                    do_begin = 1'b1;
                end
            end
            M_ERROR:
            begin
                if (is_eol(c)) begin
                    sl       = push(sl, K_ERROR, tb_reg, p);
                    do_begin = 1'b1;
                end
            end
            M_ADDR:
            begin
                v4_next = v4_feed(v4_reg, c, 1'b0);
                v6_next = v6_feed(v6_reg, c, 1'b0);
                if (is_delim(c, 1'b0)) begin
                    if (v4_next.phase == P_ACC) begin
                        sl       = push(sl, K_IPV4, tb_reg, p);
                        at_next  = 1'b1;
                        do_begin = 1'b1;
                    end else if (v6_next.phase == V6_ACC) begin
                        sl       = push(sl, K_IPV6, tb_reg, p);
                        at_next  = 1'b1;
                        do_begin = 1'b1;
                    end else begin
                        mode_next = M_ERROR;
                        if (is_eol(c)) begin
                            sl       = push(sl, K_ERROR, tb_reg, p);
                            do_begin = 1'b1;
                        end
                    end
                end else if (v4_next.phase == P_FAIL && v6_next.phase == V6_FAIL) begin
                    mode_next = M_ERROR;
                end
            end
            M_NAME:
            begin
                name_next = name_feed(name_reg, c, 1'b0);
                if (is_delim(c, 1'b0)) begin
                    if (name_next == N_ACC) begin
                        sl       = push(sl, K_HOST, tb_reg, p);
                        do_begin = 1'b1;
                    end else begin
                        mode_next = M_ERROR;
                        if (is_eol(c)) begin
                            sl       = push(sl, K_ERROR, tb_reg, p);
                            do_begin = 1'b1;
                        end
                    end
                end else if (name_next == N_FAIL) begin
                    mode_next = M_ERROR;
                end
            end
            default:
            begin
                do_begin = 1'b1;
            end
        endcase

        // open the next token on the closing character
        if (do_begin) begin
            tb_next = p;
            if (c == CH_CR) begin
                mode_next = M_CR;
            end else if (c == CH_LF) begin
                sl        = push(sl, K_NEWLINE, p, pi);
                at_next   = 1'b0;
                mode_next = M_IDLE;
            end else if (is_blank(c)) begin
                mode_next = M_BLANKS;
            end else if (c == CH_HASH) begin
                mode_next = M_COMMENT;
            end else if (!at_next) begin
                v4_next   = v4_feed('0, c, 1'b0);
                v6_next   = v6_feed('0, c, 1'b0);
                mode_next = (v4_next.phase == P_FAIL && v6_next.phase == V6_FAIL) ?
                            M_ERROR : M_ADDR;
            end else if (is_alpha(c)) begin
                name_next = name_feed(N_START, c, 1'b0);
                mode_next = M_NAME;
            end else begin
                mode_next = M_ERROR;
            end
        end

        // end of file closes whatever is open, then everything resets
        if (fin) begin
            case (mode_next)
                M_CR:      sl = push(sl, K_NEWLINE, tb_next, pi);
                M_BLANKS:  sl = push(sl, K_BLANKS, tb_next, pi);
                M_COMMENT: sl = push(sl, K_COMMENT, tb_next, pi);
                M_ERROR:   sl = push(sl, K_ERROR, tb_next, pi);
                M_ADDR:
                begin
                    f4 = v4_feed(v4_next, c, 1'b1);
                    f6 = v6_feed(v6_next, c, 1'b1);
                    if (f4.phase == P_ACC) begin
                        sl = push(sl, K_IPV4, tb_next, pi);
                    end else if (f6.phase == V6_ACC) begin
                        sl = push(sl, K_IPV6, tb_next, pi);
                    end else begin
                        sl = push(sl, K_ERROR, tb_next, pi);
                    end
                end
                M_NAME:
                begin
                    fn = name_feed(name_next, c, 1'b1);
                    sl = push(sl, (fn == N_ACC) ? K_HOST : K_ERROR, tb_next, pi);
                end
                default:   sl = sl;
            endcase
            pos_next  = '0;
            tb_next   = '0;
            mode_next = M_IDLE;
            at_next   = 1'b0;
            v4_next   = '0;
            v6_next   = '0;
            name_next = N_START;
        end

        if (sl.v1) begin
            sl.t1.run_last  = 1'b1;
            sl.t1.file_done = fin;
        end else if (sl.v0) begin
            sl.t0.run_last  = 1'b1;
            sl.t0.file_done = fin;
        end
        sl.push = accept;
        slots   = sl;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg  <= '0;
            tb_reg   <= '0;
            mode_reg <= M_IDLE;
            at_reg   <= 1'b0;
            v4_reg   <= '0;
            v6_reg   <= '0;
            name_reg <= N_START;
        end else if (accept) begin
            pos_reg  <= pos_next;
            tb_reg   <= tb_next;
            mode_reg <= mode_next;
            at_reg   <= at_next;
            v4_reg   <= v4_next;
            v6_reg   <= v6_next;
            name_reg <= name_next;
        end
    end

endmodule

FILE: rtl/hlt_tok_queue.sv
// ----------------------------------------------------------------------------
// Hosts line tokenizer token queue
// Small FIFO; takes up to two tokens a cycle, gives out one.
// ----------------------------------------------------------------------------
`include "hosts_line_tokenizer_core_defines.svh"

module hlt_tok_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  hlt_pkg::slots_t slots,
    output logic            space,
    output logic            not_empty,
    output hlt_pkg::tok_t   head,
    input  logic            pop
);
    import hlt_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    tok_t          entries_reg [QUEUE_DEPTH];
    logic [AW-1:0] wr_reg, wr_next;
    logic [AW-1:0] rd_reg, rd_next;
    logic [CW-1:0] count_reg, count_next;
    logic          w0;
    logic          w1;
    logic [AW-1:0] wr_plus1;

    assign w0        = slots.push && slots.v0;
    assign w1        = slots.push && slots.v1;
    assign wr_plus1  = wr_reg + 1'b1;
    assign space     = count_reg <= CW'(QUEUE_DEPTH - 2);
    assign not_empty = count_reg != '0;
    assign head      = entries_reg[rd_reg];

    always_comb
    begin
        wr_next    = wr_reg + AW'(w0) + AW'(w1);
        rd_next    = rd_reg + AW'(pop);
        count_next = count_reg + CW'(w0) + CW'(w1) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (w0) begin
            entries_reg[wr_reg] <= slots.t0;
        end
        if (w1) begin
            entries_reg[wr_plus1] <= slots.t1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    `HLT_ASSERT(a_count_bound, count_reg <= CW'(QUEUE_DEPTH))
    `HLT_ASSERT(a_no_overrun, slots.push |-> space)
    `HLT_ASSERT(a_ptr_gap, (count_reg == '0) |-> (wr_reg == rd_reg))
    `HLT_ASSERT_NEXT(a_pop_drains, pop && !w0, count_reg == $past(count_reg) - 1'b1)

endmodule

FILE: rtl/hlt_back.sv
// ----------------------------------------------------------------------------
// Hosts line tokenizer back end
// Output register that drives the token channel from the queue head.
// ----------------------------------------------------------------------------
module hlt_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          not_empty,
    input  hlt_pkg::tok_t head,
    output logic          pop,
    hlt_tok_if.source     tokens
);
    import hlt_pkg::*;

    logic valid_reg;
    tok_t tok_reg;

    assign pop = not_empty && (!valid_reg || tokens.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (!valid_reg || tokens.ready) begin
            valid_reg <= not_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop) begin
            tok_reg <= head;
        end
    end

    assign tokens.valid       = valid_reg;
    assign tokens.token_kind  = tok_reg.kind;
    assign tokens.token_start = tok_reg.start_pos;
    assign tokens.token_end   = tok_reg.end_pos;
    assign tokens.run_last    = tok_reg.run_last;
    assign tokens.file_done   = tok_reg.file_done;

endmodule

FILE: bench/tb_hosts_line_tokenizer_core.sv
// ----------------------------------------------------------------------------
// Hosts line tokenizer testbench
// Streams hosts-file text (directed lines, random well-formed and damaged
// lines, raw noise) into the core under random idling on both channels and
// checks every token against a cycle-free model of the tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_hosts_line_tokenizer_core;

    localparam int          CYCLE_LIMIT = 400000;
    localparam int          RANDOM_ITEMS = 1300;
    localparam int          TOTAL_ITEMS  = 1550;
    localparam logic [19:0] POS_TOP      = 20'hFFFFF;
    localparam logic [16:0] EOF_MARK     = 17'h10000;

    // lexer modes and recognizer phases of the model
    typedef enum logic [2:0] {LX_IDLE, LX_CR, LX_BLANKS, LX_COMMENT, LX_ADDR, LX_NAME,
                              LX_ERROR} lex_mode_e;
    typedef enum logic [1:0] {Q4_RUN, Q4_OK, Q4_BAD} v4_phase_e;
    typedef enum logic [2:0] {Q6_START, Q6_COLON1, Q6_DOUBLE, Q6_SINGLE, Q6_GAPSEP,
                              Q6_GROUP, Q6_OK, Q6_BAD} v6_phase_e;
    typedef enum logic [2:0] {HN_START, HN_BODY, HN_SEP, HN_OK, HN_BAD} hn_phase_e;

    typedef struct {
        logic [2:0]  kind;
        logic [19:0] start_pos;
        logic [19:0] end_pos;
        logic        run_last;
        logic        file_done;
    } token_rec_t;

    logic clk;
    logic rst_n;

    hlt_char_if chars ();
    hlt_tok_if  tokens ();

    hosts_line_tokenizer_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars),
        .tokens (tokens)
    );

    // model state
    logic [19:0] lx_pos;
    logic [19:0] lx_begin;
    lex_mode_e   lx_mode;
    bit          lx_addr_seen;
    v4_phase_e   q4_phase;
    int          q4_groups;
    int          q4_digits;
    int          q4_value;
    v6_phase_e   q6_phase;
    bit          q6_dbl;
    int          q6_groups;
    int          q6_digits;
    hn_phase_e   hn_phase;

    token_rec_t  step_tokens[$];
    token_rec_t  pending_tokens[$];
    logic [15:0] file_text[$];

    int  cycles;
    int  chars_sent;
    int  tokens_seen;
    int  files_sent;
    int  mismatches;
    bit  quiet;

    // ------------------------------------------------------------------------
    // Character classes (EOF_MARK stands for the end of the file)
    // ------------------------------------------------------------------------
    function automatic bit ch_digit(logic [16:0] c);
        return c >= 17'h30 && c <= 17'h39;
    endfunction

    function automatic bit ch_alpha(logic [16:0] c);
        return (c >= 17'h41 && c <= 17'h5A) || (c >= 17'h61 && c <= 17'h7A);
    endfunction

    function automatic bit ch_hex(logic [16:0] c);
        return ch_digit(c) || (c >= 17'h41 && c <= 17'h46) || (c >= 17'h61 && c <= 17'h66);
    endfunction

    function automatic bit ch_blank(logic [16:0] c);
        return c == {1'b0, hlt_pkg::CH_SP} || c == {1'b0, hlt_pkg::CH_HT};
    endfunction

    function automatic bit ch_eol(logic [16:0] c);
        return c == {1'b0, hlt_pkg::CH_CR} || c == {1'b0, hlt_pkg::CH_LF};
    endfunction

    function automatic bit ch_delim(logic [16:0] c);
        return ch_blank(c) || ch_eol(c) || c == {1'b0, hlt_pkg::CH_HASH} || c == EOF_MARK;
    endfunction

    function automatic logic [19:0] pos_next(logic [19:0] p);
        return (p == POS_TOP) ? p : p + 20'd1;
    endfunction

    // ------------------------------------------------------------------------
    // Tokenizer model
    // ------------------------------------------------------------------------
    function automatic void lexer_clear();
        lx_pos       = '0;
        lx_begin     = '0;
        lx_mode      = LX_IDLE;
        lx_addr_seen = 0;
        q4_phase = Q4_RUN; q4_groups = 0; q4_digits = 0; q4_value = 0;
        q6_phase = Q6_START; q6_dbl = 0; q6_groups = 0; q6_digits = 0;
        hn_phase = HN_START;
    endfunction

    function automatic void close_token(logic [2:0] kind, logic [19:0] s, logic [19:0] e);
        token_rec_t t;
        if (step_tokens.size() >= 2)
            return;
        t.kind      = kind;
        t.start_pos = s;
        t.end_pos   = e;
        t.run_last  = 0;
        t.file_done = 0;
        step_tokens.push_back(t);
    endfunction

    function automatic void ipv4_track(logic [16:0] c);
        if (q4_phase != Q4_RUN)
            return;
        if (ch_delim(c))
            q4_phase = (q4_groups == 3 && q4_digits >= 1) ? Q4_OK : Q4_BAD;
        else if (ch_digit(c))
        begin
            if (q4_digits >= 3)
                q4_phase = Q4_BAD;
            else
            begin
                q4_value = q4_value * 10 + int'(c - 17'h30);
                if (q4_value > 255)
                    q4_phase = Q4_BAD;
                else
                    q4_digits++;
            end
        end
        else if (c == {1'b0, hlt_pkg::CH_DOT})
        begin
            if (q4_digits == 0 || q4_groups >= 3)
                q4_phase = Q4_BAD;
            else
            begin
                q4_groups++;
                q4_digits = 0;
                q4_value  = 0;
            end
        end
        else
            q4_phase = Q4_BAD;
    endfunction

    function automatic void ipv6_track(logic [16:0] c);
        bit hx;
        bit cl;
        bit dl;
        hx = ch_hex(c);
        cl = (c == {1'b0, hlt_pkg::CH_COLON});
        dl = ch_delim(c);
        case (q6_phase)
            Q6_START, Q6_SINGLE:
            begin
                if (cl)
                    q6_phase = (q6_phase == Q6_START) ? Q6_COLON1 : Q6_DOUBLE;
                else if (hx)
                begin
                    q6_phase  = Q6_GROUP;
                    q6_digits = 1;
                end
                else
                    q6_phase = Q6_BAD;
            end
            Q6_COLON1:
                q6_phase = cl ? Q6_DOUBLE : Q6_BAD;
            Q6_DOUBLE:
            begin
                if (dl)
                    q6_phase = Q6_OK;
                else
                begin
                    q6_dbl = 1;
                    if (hx)
                    begin
                        q6_phase  = Q6_GROUP;
                        q6_digits = 1;
                    end
                    else
                        q6_phase = Q6_BAD;
                end
            end
            Q6_GAPSEP:
            begin
                if (hx)
                begin
                    q6_phase  = Q6_GROUP;
                    q6_digits = 1;
                end
                else
                    q6_phase = Q6_BAD;
            end
            Q6_GROUP:
            begin
                if (hx && q6_digits < 4)
                    q6_digits++;
                else
                begin
                    if (q6_groups < 8)
                        q6_groups++;
                    q6_digits = 0;
                    if (!q6_dbl)
                    begin
                        if (q6_groups == 8)
                            q6_phase = dl ? Q6_OK : Q6_BAD;
                        else
                            q6_phase = cl ? Q6_SINGLE : Q6_BAD;
                    end
                    else if (q6_groups == 7)
                        q6_phase = dl ? Q6_OK : Q6_BAD;
                    else if (cl)
                        q6_phase = Q6_GAPSEP;
                    else
                        q6_phase = dl ? Q6_OK : Q6_BAD;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void name_track(logic [16:0] c);
        case (hn_phase)
            HN_START:
                hn_phase = ch_alpha(c) ? HN_BODY : HN_BAD;
            HN_BODY:
            begin
                if (ch_delim(c))
                    hn_phase = HN_OK;
                else if (ch_alpha(c) || ch_digit(c))
                    hn_phase = HN_BODY;
                else if (c == {1'b0, hlt_pkg::CH_DASH} || c == {1'b0, hlt_pkg::CH_DOT})
                    hn_phase = HN_SEP;
                else
                    hn_phase = HN_BAD;
            end
            HN_SEP:
                hn_phase = (ch_alpha(c) || ch_digit(c)) ? HN_BODY : HN_BAD;
            default:
            begin
            end
        endcase
    endfunction

    function automatic void open_token(logic [16:0] c, logic [19:0] p);
        lx_begin = p;
        if (c == {1'b0, hlt_pkg::CH_CR})
            lx_mode = LX_CR;
        else if (c == {1'b0, hlt_pkg::CH_LF})
        begin
            close_token(hlt_pkg::K_NEWLINE, p, pos_next(p));
            lx_addr_seen = 0;
            lx_mode      = LX_IDLE;
        end
        else if (ch_blank(c))
            lx_mode = LX_BLANKS;
        else if (c == {1'b0, hlt_pkg::CH_HASH})
            lx_mode = LX_COMMENT;
        else if (!lx_addr_seen)
        begin
            q4_phase = Q4_RUN; q4_groups = 0; q4_digits = 0; q4_value = 0;
            q6_phase = Q6_START; q6_dbl = 0; q6_groups = 0; q6_digits = 0;
            ipv4_track(c);
            ipv6_track(c);
            lx_mode = (q4_phase == Q4_BAD && q6_phase == Q6_BAD) ? LX_ERROR : LX_ADDR;
        end
        else if (ch_alpha(c))
        begin
            hn_phase = HN_START;
            name_track(c);
            lx_mode = LX_NAME;
        end
        else
            lx_mode = LX_ERROR;
    endfunction

    // an error token runs on until the end of the line
    function automatic void error_run(logic [16:0] c, logic [19:0] p);
        lx_mode = LX_ERROR;
        if (ch_eol(c))
        begin
            close_token(hlt_pkg::K_ERROR, lx_begin, p);
            open_token(c, p);
        end
    endfunction

    // one accepted character: appends the tokens it closes to pending_tokens
    function automatic void tokenize_char(logic [15:0] ch, logic fin);
        logic [16:0] c;
        logic [19:0] p;
        logic [19:0] e;
        c = {1'b0, ch};
        p = lx_pos;
        step_tokens.delete();
        case (lx_mode)
            LX_CR:
            begin
                if (ch == hlt_pkg::CH_LF)
                begin
                    close_token(hlt_pkg::K_NEWLINE, lx_begin, pos_next(p));
                    lx_addr_seen = 0;
                    lx_mode      = LX_IDLE;
                end
                else
                begin
                    close_token(hlt_pkg::K_NEWLINE, lx_begin, p);
                    lx_addr_seen = 0;
                    open_token(c, p);
                end
            end
            LX_BLANKS:
                if (!ch_blank(c))
                begin
                    close_token(hlt_pkg::K_BLANKS, lx_begin, p);
                    open_token(c, p);
                end
            LX_COMMENT:
                if (ch_eol(c))
                begin
                    close_token(hlt_pkg::K_COMMENT, lx_begin, p);
                    open_token(c, p);
                end
            LX_ERROR:
                error_run(c, p);
            LX_ADDR:
            begin
                ipv4_track(c);
                ipv6_track(c);
                if (ch_delim(c))
                begin
                    if (q4_phase == Q4_OK || q6_phase == Q6_OK)
                    begin
                        close_token(q4_phase == Q4_OK ? hlt_pkg::K_IPV4 : hlt_pkg::K_IPV6,
                                    lx_begin, p);
                        lx_addr_seen = 1;
                        open_token(c, p);
                    end
                    else
                        error_run(c, p);
                end
                else if (q4_phase == Q4_BAD && q6_phase == Q6_BAD)
                    lx_mode = LX_ERROR;
            end
            LX_NAME:
            begin
                name_track(c);
                if (ch_delim(c))
                begin
                    if (hn_phase == HN_OK)
                    begin
                        close_token(hlt_pkg::K_HOST, lx_begin, p);
                        open_token(c, p);
                    end
                    else
                        error_run(c, p);
                end
                else if (hn_phase == HN_BAD)
                    lx_mode = LX_ERROR;
            end
            default:
                open_token(c, p);
        endcase
        lx_pos = pos_next(p);

        // end of file closes whatever token is open
        if (fin)
        begin
            e = lx_pos;
            case (lx_mode)
                LX_CR:      close_token(hlt_pkg::K_NEWLINE, lx_begin, e);
                LX_BLANKS:  close_token(hlt_pkg::K_BLANKS, lx_begin, e);
                LX_COMMENT: close_token(hlt_pkg::K_COMMENT, lx_begin, e);
                LX_ERROR:   close_token(hlt_pkg::K_ERROR, lx_begin, e);
                LX_ADDR:
                begin
                    ipv4_track(EOF_MARK);
                    ipv6_track(EOF_MARK);
                    if (q4_phase == Q4_OK)
                        close_token(hlt_pkg::K_IPV4, lx_begin, e);
                    else if (q6_phase == Q6_OK)
                        close_token(hlt_pkg::K_IPV6, lx_begin, e);
                    else
                        close_token(hlt_pkg::K_ERROR, lx_begin, e);
                end
                LX_NAME:
                begin
                    name_track(EOF_MARK);
                    close_token(hn_phase == HN_OK ? hlt_pkg::K_HOST : hlt_pkg::K_ERROR,
                                lx_begin, e);
                end
                default:
                begin
                end
            endcase
            lexer_clear();
        end
        if (step_tokens.size() > 0)
        begin
            step_tokens[step_tokens.size() - 1].run_last  = 1;
            step_tokens[step_tokens.size() - 1].file_done = fin;
        end
        foreach (step_tokens[i])
            pending_tokens.push_back(step_tokens[i]);
    endfunction

    // ------------------------------------------------------------------------
    // Clock, reset, timeout
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d tokens outstanding", cycles,
                     pending_tokens.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Token sink: random stall bursts, none once the run goes quiet
    // ------------------------------------------------------------------------
    initial
    begin
        tokens.ready = 1'b0;
        repeat (6) @(posedge clk);
        forever
        begin
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                tokens.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            tokens.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    // token checker: every accepted token against the oldest prediction
    always @(posedge clk)
    begin
        token_rec_t want;
        if (rst_n && tokens.valid && tokens.ready)
        begin
            tokens_seen++;
            if (pending_tokens.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected token kind %0d span %0d..%0d",
                             tokens.token_kind, tokens.token_start, tokens.token_end);
            end
            else
            begin
                want = pending_tokens.pop_front();
                if (tokens.token_kind !== want.kind || tokens.token_start !== want.start_pos
                    || tokens.token_end !== want.end_pos || tokens.run_last !== want.run_last
                    || tokens.file_done !== want.file_done)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("token mismatch: want k%0d %0d..%0d l%0b d%0b, got k%0d %0d..%0d l%0b d%0b",
                                 want.kind, want.start_pos, want.end_pos, want.run_last,
                                 want.file_done, tokens.token_kind, tokens.token_start,
                                 tokens.token_end, tokens.run_last, tokens.file_done);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Character source
    // ------------------------------------------------------------------------
    task automatic hold_off(int n);
        chars.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // one transaction on the character channel, with an occasional gap after it
    task automatic send_char(logic [15:0] ch, logic fin);
        chars.valid      <= 1'b1;
        chars.character  <= ch;
        chars.final_char <= fin;
        do
            @(posedge clk);
        while (!chars.ready);
        tokenize_char(ch, fin);
        chars_sent++;
        if (fin)
            files_sent++;
        if (!quiet && $urandom_range(0, 6) == 0)
            hold_off($urandom_range(1, 10));
    endtask

    task automatic send_text(string s, bit fin_last);
        for (int i = 0; i < s.len(); i++)
            send_char({8'h00, s[i]}, fin_last && i == s.len() - 1);
    endtask

    task automatic send_file_text(bit fin_last);
        foreach (file_text[i])
            send_char(file_text[i], fin_last && i == file_text.size() - 1);
        file_text.delete();
    endtask

    task automatic wait_drained();
        chars.valid <= 1'b0;
        while (pending_tokens.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Random text builders
    // ------------------------------------------------------------------------
    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++)
            file_text.push_back({8'h00, s[i]});
    endfunction

    function automatic void put_ipv4();
        for (int g = 0; g < 4; g++)
        begin
            if ($urandom_range(0, 11) == 0)
                put_str($sformatf("%0d", $urandom_range(256, 999)));
            else if ($urandom_range(0, 3) == 0)
                put_str($sformatf("%03d", $urandom_range(0, 255)));
            else
                put_str($sformatf("%0d", $urandom_range(0, 255)));
            if (g < 3 && $urandom_range(0, 24) != 0)
                put_str(".");
        end
    endfunction

    function automatic void put_hex_group();
        string digs;
        int    n;
        digs = "0123456789abcdefABCDEF";
        n = ($urandom_range(0, 15) == 0) ? 5 : $urandom_range(1, 4);
        repeat (n)
            file_text.push_back({8'h00, digs[$urandom_range(0, 21)]});
    endfunction

    function automatic void put_ipv6();
        int lead;
        int trail;
        if ($urandom_range(0, 2) == 0)
        begin
            lead = $urandom_range(7, 9);
            for (int g = 0; g < lead; g++)
            begin
                if (g > 0)
                    put_str(":");
                put_hex_group();
            end
        end
        else
        begin
            lead  = $urandom_range(0, 6);
            trail = $urandom_range(0, 8 - lead);
            for (int g = 0; g < lead; g++)
            begin
                put_hex_group();
                if (g < lead - 1)
                    put_str(":");
            end
            put_str("::");
            for (int g = 0; g < trail; g++)
            begin
                if (g > 0)
                    put_str(":");
                put_hex_group();
            end
        end
    endfunction

    function automatic void put_hostname();
        string al;
        int    n;
        al = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
        if ($urandom_range(0, 12) == 0)
            put_str("9");
        file_text.push_back({8'h00, al[$urandom_range(0, 51)]});
        n = $urandom_range(0, 8);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 4) == 0)
                put_str($urandom_range(0, 1) ? "-" : ".");
            file_text.push_back({8'h00, al[$urandom_range(0, 61)]});
        end
        if ($urandom_range(0, 12) == 0)
            put_str($urandom_range(0, 1) ? "-" : "_");
    endfunction

    function automatic void put_blanks();
        repeat ($urandom_range(1, 3))
            file_text.push_back($urandom_range(0, 1) ? hlt_pkg::CH_SP : hlt_pkg::CH_HT);
    endfunction

    function automatic void put_newline();
        case ($urandom_range(0, 2))
            0: file_text.push_back(hlt_pkg::CH_LF);
            1: file_text.push_back(hlt_pkg::CH_CR);
            default:
            begin
                file_text.push_back(hlt_pkg::CH_CR);
                file_text.push_back(hlt_pkg::CH_LF);
            end
        endcase
    endfunction

    // one hosts line, well formed most of the time
    function automatic void put_line();
        int fields;
        int at;
        if ($urandom_range(0, 9) == 0)
            put_blanks();
        case ($urandom_range(0, 9))
            0:
            begin
            end
            1: put_str("# note");
            default:
            begin
                if ($urandom_range(0, 1)) put_ipv4(); else put_ipv6();
                fields = $urandom_range(0, 3);
                repeat (fields)
                begin
                    put_blanks();
                    put_hostname();
                end
                if ($urandom_range(0, 3) == 0)
                begin
                    put_blanks();
                    put_str("#x");
                    file_text.push_back(16'($urandom_range(0, 65535)));
                end
            end
        endcase
        // occasional damage anywhere in the line
        if (file_text.size() > 0 && $urandom_range(0, 7) == 0)
        begin
            at = $urandom_range(0, file_text.size() - 1);
            case ($urandom_range(0, 5))
                0: file_text[at] = hlt_pkg::CH_COLON;
                1: file_text[at] = hlt_pkg::CH_DOT;
                2: file_text[at] = hlt_pkg::CH_HASH;
                3: file_text[at] = hlt_pkg::CH_DASH;
                4: file_text[at] = 16'h0041 + 16'($urandom_range(0, 25));
                default: file_text[at] = 16'($urandom_range(128, 65535));
            endcase
        end
        if ($urandom_range(0, 9) != 0)
            put_newline();
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // every token kind but error, CR LF, a double-colon-only address and a dangling CR
    task automatic test_directed();
        send_text("1.2.3.255\tz-9.a #c\015\012", 0);
        send_text("::\015", 1);
    endtask

    // whole files of random lines, some cut off at a random character
    task automatic test_random_files(int upto);
        while (chars_sent < upto)
        begin
            repeat ($urandom_range(1, 6))
                put_line();
            if (file_text.size() == 0)
                put_str("a");
            if ($urandom_range(0, 4) == 0)
                file_text = file_text[0 : $urandom_range(0, file_text.size() - 1)];
            send_file_text(1);
            if (files_sent % 11 == 5)
                test_noise();
        end
    endtask

    // raw code units over the full range, weighted towards newlines, blanks, colons and digits
    task automatic test_noise();
        logic [15:0] ch;
        repeat ($urandom_range(10, 30))
        begin
            case ($urandom_range(0, 5))
                0: ch = hlt_pkg::CH_LF;
                1: ch = hlt_pkg::CH_SP;
                2: ch = hlt_pkg::CH_COLON;
                3: ch = 16'h0030 + 16'($urandom_range(0, 9));
                default: ch = 16'($urandom_range(0, 65535));
            endcase
            file_text.push_back(ch);
        end
        file_text.push_back(16'hFFFF);
        file_text.push_back(16'h0000);
        send_file_text($urandom_range(0, 1));
    endtask

    // sender stops until the tokenizer has drained completely
    task automatic test_drain_pause();
        put_str("10.0.0.1 gw");
        send_file_text(0);
        wait_drained();
        put_str(" alias\n");
        send_file_text(1);
    endtask

    initial
    begin
        rst_n            = 1'b0;
        chars.valid      = 1'b0;
        chars.character  = '0;
        chars.final_char = 1'b0;
        cycles       = 0;
        chars_sent   = 0;
        tokens_seen  = 0;
        files_sent   = 0;
        mismatches   = 0;
        quiet        = 0;
        lexer_clear();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_drain_pause();
        test_random_files(RANDOM_ITEMS);
        // last stretch without any idling
        quiet = 1;
        test_random_files(TOTAL_ITEMS);

        wait_drained();
        repeat (20) @(posedge clk);
        if (pending_tokens.size() != 0)
            mismatches++;

        $display("covered %0d characters in %0d files, %0d tokens checked",
                 chars_sent, files_sent, tokens_seen);
        $display("addresses, names, comments, blanks, newlines and errors under stalls");
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
